// File: rtl/core/easc_pkg.sv
// Shared constants, types and table functions for the electrical angle sine/cosine block.
// Used by electrical_angle_sine_cosine, easc_sine_lane and easc_checker; depends on nothing.
package easc_pkg;

    // Phase and fixed-point widths.
    localparam int PHASE_BITS    = 16;
    localparam int FRACTION_BITS = 8;
    localparam int SEG_BITS      = 8;
    localparam int POLE_W        = 7;
    localparam int SINE_W        = 17;
    localparam int TAB_W         = 16;
    localparam int TAB_IDX_W     = 7;
    localparam int DIFF_W        = 12;
    localparam int STEP_W        = DIFF_W + FRACTION_BITS + 1;
    localparam int LOW_BITS      = PHASE_BITS - SEG_BITS;
    localparam int FRAC_DN       = (LOW_BITS >= FRACTION_BITS) ? LOW_BITS - FRACTION_BITS : 0;
    localparam int FRAC_UP       = (LOW_BITS < FRACTION_BITS) ? FRACTION_BITS - LOW_BITS : 0;
    localparam int FRAC_EXT_W    = LOW_BITS + FRACTION_BITS;
    localparam logic [POLE_W-1:0] POLE_PAIRS_RESET = POLE_W'(1);
    localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1) << (PHASE_BITS - 2);

    // Quadrant codes taken from the top two segment bits.
    localparam logic [1:0] QUAD_RISE     = 2'd0;
    localparam logic [1:0] QUAD_FALL     = 2'd1;
    localparam logic [1:0] QUAD_NEG_RISE = 2'd2;
    localparam logic [1:0] QUAD_NEG_FALL = 2'd3;

    // Quarter-wave sine table, 32768 stands for one.
    localparam logic [TAB_W-1:0] QUARTER_WAVE [0:64] = '{
        16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,
        16'd5602,  16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279,
        16'd11039, 16'd11793, 16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447,
        16'd16151, 16'd16846, 16'd17531, 16'd18205, 16'd18868, 16'd19520, 16'd20160,
        16'd20788, 16'd21403, 16'd22006, 16'd22595, 16'd23170, 16'd23732, 16'd24279,
        16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791, 16'd27246, 16'd27684,
        16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957, 16'd30274,
        16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
        16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729,
        16'd32758, 16'd32768
    };

    // Pipeline load enables handed from the top level to each sine lane.
    typedef struct packed {
        logic load2;
        logic load3;
        logic load4;
    } pipe_adv_t;

    // The two neighbouring table values of one segment, signs applied.
    typedef struct packed {
        logic signed [SINE_W-1:0] first;
        logic signed [SINE_W-1:0] second;
    } seg_pair_t;

    // Quadrant-mirrored table lookup for one segment.
    function automatic seg_pair_t seg_pair(input logic [SEG_BITS-1:0] seg);
        seg_pair_t              res;
        logic [TAB_IDX_W-1:0]   sub;
        logic [TAB_IDX_W-1:0]   idx_a;
        logic [TAB_IDX_W-1:0]   idx_b;
        logic signed [SINE_W-1:0] val_a;
        logic signed [SINE_W-1:0] val_b;
        sub = {1'b0, seg[SEG_BITS-3:0]};
        case (seg[SEG_BITS-1:SEG_BITS-2])
            QUAD_RISE, QUAD_NEG_RISE:
            begin
                idx_a = sub;
                idx_b = sub + TAB_IDX_W'(1);
            end
            QUAD_FALL, QUAD_NEG_FALL:
            begin
                idx_a = TAB_IDX_W'(64) - sub;
                idx_b = TAB_IDX_W'(63) - sub;
            end
            default:
            begin
                idx_a = sub;
                idx_b = sub;
            end
        endcase
        val_a = $signed({1'b0, QUARTER_WAVE[idx_a]});
        val_b = $signed({1'b0, QUARTER_WAVE[idx_b]});
        if (seg[SEG_BITS-1])
        begin
            res.first  = -val_a;
            res.second = -val_b;
        end
        else
        begin
            res.first  = val_a;
            res.second = val_b;
        end
        return res;
    endfunction

    // Interpolation fraction: the bits below the segment, aligned to FRACTION_BITS.
    function automatic logic [FRACTION_BITS-1:0] frac_of(input logic [PHASE_BITS-1:0] phase);
        logic [FRAC_EXT_W-1:0] ext;
        ext = FRAC_EXT_W'(phase[LOW_BITS-1:0]);
        return FRACTION_BITS'((ext << FRAC_UP) >> FRAC_DN);
    endfunction

endpackage

// File: rtl/core/easc_sine_lane.sv
// One sine lane: table lookup, interpolation multiply and final add over three stages.
// Depends on easc_pkg; the load enables come from the top level.
module easc_sine_lane (
    input  logic                                  clk,
    input  logic [easc_pkg::PHASE_BITS-1:0]       phase,
    input  easc_pkg::pipe_adv_t                   adv,
    output logic signed [easc_pkg::SINE_W-1:0]    value
);
    import easc_pkg::*;

    logic signed [SINE_W-1:0]  first2_reg;
    logic signed [DIFF_W-1:0]  diff2_reg;
    logic [FRACTION_BITS-1:0]  frac2_reg;
    logic signed [SINE_W-1:0]  first3_reg;
    logic signed [STEP_W-1:0]  prod3_reg;
    logic signed [SINE_W-1:0]  value_reg;

    seg_pair_t                 pair;
    logic signed [SINE_W-1:0]  diff_full;
    logic signed [DIFF_W-1:0]  diff2_next;
    logic signed [STEP_W-1:0]  prod3_next;
    logic signed [STEP_W-1:0]  step;
    logic signed [SINE_W-1:0]  value_next;

    // Stage two: mirrored table lookup and the slope of the segment.
    assign pair       = seg_pair(phase[PHASE_BITS-1 -: SEG_BITS]);
    assign diff_full  = pair.second - pair.first;
    assign diff2_next = DIFF_W'(diff_full);

    always_ff @(posedge clk)
    begin
        if (adv.load2)
        begin
            first2_reg <= pair.first;
            diff2_reg  <= diff2_next;
            frac2_reg  <= frac_of(phase);
        end
    end

    // Stage three: slope times fraction.
    assign prod3_next = STEP_W'(diff2_reg) * $signed({1'b0, frac2_reg});

    always_ff @(posedge clk)
    begin
        if (adv.load3)
        begin
            first3_reg <= first2_reg;
            prod3_reg  <= prod3_next;
        end
    end

    // Stage four: the arithmetic shift floors the step towards minus infinity.
    assign step       = prod3_reg >>> FRACTION_BITS;
    assign value_next = first3_reg + SINE_W'(step);

    always_ff @(posedge clk)
    begin
        if (adv.load4)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// File: rtl/core/electrical_angle_sine_cosine.sv
// Top level of the electrical angle sine/cosine block.
// Depends on easc_pkg and instantiates two easc_sine_lane units.
//
// Usage:
// A shaft phase is offered on shaft_valid/shaft_ready/shaft_phase, where 65536 is one
// turn. Each transfer gives one result on result_valid/result_ready carrying the
// electrical phase (shaft phase times pole pairs, wrapped to one turn) and its sine
// and cosine in two's complement with 32768 standing for one.
// The pole-pair count is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high, and writes are meant to happen only while the pipeline is empty.
// The pipeline has four register stages (pole-pair multiply, table lookup,
// interpolation multiply, final add) and, while the receiver takes each result,
// accepts one item in every cycle, so throughput is one result per cycle.
// When the receiver stalls, the result holds and the stages behind it keep filling
// their empty slots; shaft_ready falls only once every stage holds an item.
// Reset empties the pipeline and sets the pole-pair count to one.
module electrical_angle_sine_cosine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [easc_pkg::POLE_W-1:0]           cfg_data,
    input  logic                                  shaft_valid,
    output logic                                  shaft_ready,
    input  logic [easc_pkg::PHASE_BITS-1:0]       shaft_phase,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [easc_pkg::PHASE_BITS-1:0]       electrical_phase,
    output logic signed [easc_pkg::SINE_W-1:0]    sine_value,
    output logic signed [easc_pkg::SINE_W-1:0]    cosine_value
);
    import easc_pkg::*;

    localparam int MUL_W = PHASE_BITS + POLE_W;

    logic [POLE_W-1:0]     pole_pairs_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  v4_reg;
    logic [PHASE_BITS-1:0] elec1_reg;
    logic [PHASE_BITS-1:0] elec2_reg;
    logic [PHASE_BITS-1:0] elec3_reg;
    logic [PHASE_BITS-1:0] elec4_reg;

    logic                  load1;
    logic                  load2;
    logic                  load3;
    logic                  load4;
    logic [MUL_W-1:0]      mul;
    logic [PHASE_BITS-1:0] elec1_next;
    logic [PHASE_BITS-1:0] cos_phase;
    pipe_adv_t             adv;

    // Configuration register; a write is always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_pairs_reg <= POLE_PAIRS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pole_pairs_reg <= cfg_data;
        end
    end

    // A stage loads when it is empty or its content moves on.
    assign load4       = !v4_reg || result_ready;
    assign load3       = !v3_reg || load4;
    assign load2       = !v2_reg || load3;
    assign load1       = !v1_reg || load2;
    assign shaft_ready = load1;
    assign adv         = '{load2, load3, load4};

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= shaft_valid;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
            if (load4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage one: electrical phase is the product wrapped to one turn.
    assign mul        = MUL_W'(shaft_phase) * MUL_W'(pole_pairs_reg);
    assign elec1_next = mul[PHASE_BITS-1:0];

    // Electrical phase follows the lanes through the remaining stages.
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            elec1_reg <= elec1_next;
        end
        if (load2)
        begin
            elec2_reg <= elec1_reg;
        end
        if (load3)
        begin
            elec3_reg <= elec2_reg;
        end
        if (load4)
        begin
            elec4_reg <= elec3_reg;
        end
    end

    // The cosine is the sine a quarter turn ahead.
    assign cos_phase = elec1_reg + QUARTER_TURN;

    easc_sine_lane u_sine (
        .clk   (clk),
        .phase (elec1_reg),
        .adv   (adv),
        .value (sine_value)
    );

    easc_sine_lane u_cosine (
        .clk   (clk),
        .phase (cos_phase),
        .adv   (adv),
        .value (cosine_value)
    );

    assign result_valid     = v4_reg;
    assign electrical_phase = elec4_reg;

endmodule

// File: rtl/core/easc_checker.sv
// Port-level checker for electrical_angle_sine_cosine, attached by the bind below.
// Depends on easc_pkg for the port widths.
module easc_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  shaft_valid,
    input logic                                  shaft_ready,
    input logic                                  result_valid,
    input logic                                  result_ready,
    input logic [easc_pkg::PHASE_BITS-1:0]       electrical_phase,
    input logic signed [easc_pkg::SINE_W-1:0]    sine_value,
    input logic signed [easc_pkg::SINE_W-1:0]    cosine_value
);
    import easc_pkg::*;

    // A stalled result holds its valid and its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(electrical_phase)
            && $stable(sine_value) && $stable(cosine_value))
        else $error("stalled result changed");

    // With the receiver ready, an input transfer moves through the stage registers to a result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready && $past(result_ready) && $past(result_ready, 2)
            && $past(shaft_valid && shaft_ready, 3)
            && $past(rst_n) && $past(rst_n, 2) && $past(rst_n, 3)
            |=> result_valid)
        else $error("result missing after pipeline latency");

    // Sine and cosine stay within plus and minus one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sine_value <= 32768 && sine_value >= -32768
            && cosine_value <= 32768 && cosine_value >= -32768)
        else $error("sine or cosine out of range");

    // At least one of sine and cosine is at least one half in magnitude.
    a_unit_circle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sine_value >= 16384 || sine_value <= -16384
            || cosine_value >= 16384 || cosine_value <= -16384)
        else $error("sine and cosine both too small");

endmodule

bind electrical_angle_sine_cosine easc_checker u_easc_checker (.*);
